>>> rtl/ppu_pkg.sv
package ppu_pkg;

    localparam int DATA_W          = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W       = 3;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODEL_READY = 3'd0,
        CFG_FOCAL_X     = 3'd1,
        CFG_FOCAL_Y     = 3'd2,
        CFG_SKEW        = 3'd3,
        CFG_CENTER_X    = 3'd4,
        CFG_CENTER_Y    = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_PROJECT   = 1'b0,
        OP_UNPROJECT = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                     model_ready;
        logic signed [DATA_W-1:0] focal_x;
        logic signed [DATA_W-1:0] focal_y;
        logic signed [DATA_W-1:0] skew;
        logic signed [DATA_W-1:0] center_x;
        logic signed [DATA_W-1:0] center_y;
    } cfg_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic                     unproj;
        logic                     rej;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } req_t;

    typedef struct packed {
        logic lane_a_valid;
        logic lane_b_valid;
    } back_stat_t;

endpackage

>>> rtl/pinhole_project_unproject_top.sv
// Pinhole camera projection and unprojection in signed fixed point.
// Requests enter on the s_ channel (valid/ready): opcode 0 projects the ray
// (s_in_x, s_in_y, s_in_z) to a pixel, opcode 1 unprojects the pixel
// (s_in_x, s_in_y) to a ray of unit depth. Each request yields exactly one
// transaction on the m_ channel, in order, with m_ok low on a rejected
// request or on overflow.
// Intrinsics are written through cfg_wr_en/cfg_index/cfg_wr_data while the
// block is idle; model_ready must be set before any request can succeed.
// Throughput is one transaction per cycle unless m_ready holds the back
// pipeline. Each result passes through the two bit-per-stage divider
// pipelines in series plus the queue, saturation, multiply and sum stages.
// With m_valid high and m_ready low the whole back pipeline holds; the front
// keeps taking transactions into its queue until it is full, then drops
// s_ready. Reset clears the queue and pipeline valids and loads the default
// intrinsics (unit focal lengths, zero skew and center, model not ready).
module pinhole_project_unproject_top #(
    parameter int FRAC_BITS   = ppu_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = ppu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ppu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppu_pkg::DATA_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic signed [ppu_pkg::DATA_W-1:0]    s_in_x,
    input  logic signed [ppu_pkg::DATA_W-1:0]    s_in_y,
    input  logic signed [ppu_pkg::DATA_W-1:0]    s_in_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_ok,
    output logic signed [ppu_pkg::DATA_W-1:0]    m_out_x,
    output logic signed [ppu_pkg::DATA_W-1:0]    m_out_y,
    output logic signed [ppu_pkg::DATA_W-1:0]    m_out_z
);
    import ppu_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.model_ready <= 1'b0;
            cfg_reg.focal_x     <= ONE;
            cfg_reg.focal_y     <= ONE;
            cfg_reg.skew        <= '0;
            cfg_reg.center_x    <= '0;
            cfg_reg.center_y    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODEL_READY: cfg_reg.model_ready <= cfg_wr_data[0];
                CFG_FOCAL_X:     cfg_reg.focal_x     <= cfg_wr_data;
                CFG_FOCAL_Y:     cfg_reg.focal_y     <= cfg_wr_data;
                CFG_SKEW:        cfg_reg.skew        <= cfg_wr_data;
                CFG_CENTER_X:    cfg_reg.center_x    <= cfg_wr_data;
                CFG_CENTER_Y:    cfg_reg.center_y    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic                               q_valid, q_pop;
    req_t                               q_data;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level;
    back_stat_t                         stat;

    ppu_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_in_x(s_in_x), .s_in_y(s_in_y), .s_in_z(s_in_z),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .q_level(q_level)
    );

    ppu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .stat(stat)
    );

    // The two first-stage divider lanes run in lock step.
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.lane_a_valid == stat.lane_b_valid)
        else $error("divider lanes out of step");

    // The queue never overfills and s_ready reflects its fill level.
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)) &&
        (s_ready == (q_level != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))))
        else $error("queue level inconsistent with s_ready");

    // A good result carries depth zero (pixel) or one (ray).
    a_depth_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ok) |-> (m_out_z == '0 || m_out_z == ONE))
        else $error("unexpected depth on a good result");

    // Nothing is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        (aresetn && !$past(aresetn)) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

>>> rtl/ppu_front.sv
module ppu_front #(
    parameter int QUEUE_DEPTH = ppu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ppu_pkg::cfg_t                      cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic signed [ppu_pkg::DATA_W-1:0]  s_in_x,
    input  logic signed [ppu_pkg::DATA_W-1:0]  s_in_y,
    input  logic signed [ppu_pkg::DATA_W-1:0]  s_in_z,
    output logic                               q_valid,
    output ppu_pkg::req_t                      q_data,
    input  logic                               q_pop,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level
);
    import ppu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    req_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    req_t             req;
    logic             push, pop;

    // A request fails without model_ready, z <= 0 (project) or focal <= 0 (unproject).
    always_comb begin
        req.unproj = (opcode_t'(s_opcode) == OP_UNPROJECT);
        req.x      = s_in_x;
        req.y      = s_in_y;
        req.z      = s_in_z;
        if (!cfg.model_ready) begin
            req.rej = 1'b1;
        end else if (req.unproj) begin
            req.rej = (cfg.focal_x <= 0) || (cfg.focal_y <= 0);
        end else begin
            req.rej = (s_in_z <= 0);
        end
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;
    assign q_level = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= req;
        end
    end

    assign q_data = mem[rd_ptr_reg];

endmodule

>>> rtl/ppu_div.sv
module ppu_div #(
    parameter int DW = 49,
    parameter int VW = 32,
    parameter int TW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_dividend,
    input  logic [VW-1:0] in_divisor,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [DW-1:0] out_quot,
    output logic [TW-1:0] out_tag
);
    // Unsigned restoring divider, one quotient bit per stage. The dividend
    // register shifts left and collects the quotient bits at its bottom.
    logic          vld_reg [DW+1];
    logic [VW-1:0] rem_reg [DW+1];
    logic [DW-1:0] dvd_reg [DW+1];
    logic [VW-1:0] dsr_reg [DW+1];
    logic [TW-1:0] tag_reg [DW+1];
    logic [VW-1:0] rem_next [DW+1];
    logic [DW-1:0] dvd_next [DW+1];

    always_comb begin
        logic [VW:0] trial;
        logic        ge;
        rem_next[0] = '0;
        dvd_next[0] = in_dividend;
        for (int k = 1; k <= DW; k++) begin
            trial       = {rem_reg[k-1], dvd_reg[k-1][DW-1]};
            ge          = (trial >= {1'b0, dsr_reg[k-1]});
            rem_next[k] = ge ? VW'(trial - {1'b0, dsr_reg[k-1]}) : trial[VW-1:0];
            dvd_next[k] = {dvd_reg[k-1][DW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= DW; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dsr_reg[0] <= in_divisor;
            tag_reg[0] <= in_tag;
            for (int k = 1; k <= DW; k++) begin
                dsr_reg[k] <= dsr_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
            for (int k = 0; k <= DW; k++) begin
                rem_reg[k] <= rem_next[k];
                dvd_reg[k] <= dvd_next[k];
            end
        end
    end

    assign out_valid = vld_reg[DW];
    assign out_quot  = dvd_reg[DW];
    assign out_tag   = tag_reg[DW];

endmodule

>>> rtl/ppu_back.sv
module ppu_back #(
    parameter int FRAC_BITS = ppu_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ppu_pkg::cfg_t                      cfg,
    input  logic                               q_valid,
    input  ppu_pkg::req_t                      q_data,
    output logic                               q_pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic signed [ppu_pkg::DATA_W-1:0]  m_out_x,
    output logic signed [ppu_pkg::DATA_W-1:0]  m_out_y,
    output logic signed [ppu_pkg::DATA_W-1:0]  m_out_z,
    output ppu_pkg::back_stat_t                stat
);
    import ppu_pkg::*;

    localparam int D1W   = 33 + FRAC_BITS;
    localparam int NUMW  = (((33 + FRAC_BITS) > 64) ? (33 + FRAC_BITS) : 64) + 1;
    localparam int QMAXW = (D1W > NUMW) ? D1W : NUMW;
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic                     fit;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    typedef struct packed {
        logic                     unproj;
        logic                     rej;
        logic                     neg;
        logic signed [DATA_W-1:0] a;
    } ctx1_t;

    typedef struct packed {
        logic                     unproj;
        logic                     rej;
        logic                     ok;
        logic                     neg;
        logic signed [DATA_W-1:0] rx;
        logic signed [DATA_W-1:0] ry;
    } ctx2_t;

    // Saturate a signed quotient given as magnitude and sign.
    function automatic sat_t qsat(input logic [QMAXW-1:0] q, input logic neg);
        sat_t r;
        logic big;
        big   = neg ? ((|q[QMAXW-1:32]) || (q[31] && (|q[30:0]))) : (|q[QMAXW-1:31]);
        r.fit = !big;
        if (big) begin
            r.val = neg ? S32_MIN : S32_MAX;
        end else begin
            r.val = neg ? (DATA_W'(0) - q[31:0]) : q[31:0];
        end
        return r;
    endfunction

    function automatic sat_t wsat(input logic signed [65:0] v);
        sat_t r;
        logic [34:0] hi;
        hi    = v[65:31];
        r.fit = (&hi) || !(|hi);
        if (r.fit) begin
            r.val = v[31:0];
        end else begin
            r.val = v[65] ? S32_MIN : S32_MAX;
        end
        return r;
    endfunction

    logic en;
    assign en    = !m_valid || m_ready;
    assign q_pop = en && q_valid;

    // Operand preparation for the first pair of divisions.
    logic [DATA_W-1:0]  xabs;
    logic signed [32:0] numb;
    logic [32:0]        babs;
    logic [D1W-1:0]     dvd_a, dvd_b;
    logic [DATA_W-1:0]  dsr_b;
    ctx1_t              ctx1_in, ctx1_out;
    logic               nega_out, va_out, vb_out;
    logic [D1W-1:0]     qa, qb;
    logic [$bits(ctx1_t)-1:0] tag1_out;

    always_comb begin
        xabs  = q_data.x[31] ? (DATA_W'(0) - q_data.x) : q_data.x;
        numb  = q_data.unproj ? ({q_data.y[31], q_data.y} - {cfg.center_y[31], cfg.center_y})
                              : {q_data.y[31], q_data.y};
        babs  = numb[32] ? (33'd0 - numb) : numb;
        dvd_a = {1'b0, xabs, {FRAC_BITS{1'b0}}};
        dvd_b = {babs, {FRAC_BITS{1'b0}}};
        dsr_b = q_data.unproj ? cfg.focal_y : q_data.z;
        ctx1_in.unproj = q_data.unproj;
        ctx1_in.rej    = q_data.rej;
        ctx1_in.neg    = numb[32];
        ctx1_in.a      = q_data.x;
    end

    ppu_div #(.DW(D1W), .VW(DATA_W), .TW(1)) u_div_a (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(q_valid), .in_dividend(dvd_a), .in_divisor(q_data.z),
        .in_tag(q_data.x[31]),
        .out_valid(va_out), .out_quot(qa), .out_tag(nega_out)
    );

    ppu_div #(.DW(D1W), .VW(DATA_W), .TW($bits(ctx1_t))) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(q_valid), .in_dividend(dvd_b), .in_divisor(dsr_b),
        .in_tag(ctx1_in),
        .out_valid(vb_out), .out_quot(qb), .out_tag(tag1_out)
    );

    assign ctx1_out = ctx1_t'(tag1_out);
    assign stat.lane_a_valid = va_out;
    assign stat.lane_b_valid = vb_out;

    // Saturation of the normalized coordinates.
    sat_t sat_xn, sat_yn;
    assign sat_xn = qsat(QMAXW'(qa), nega_out);
    assign sat_yn = qsat(QMAXW'(qb), ctx1_out.neg);

    logic                     s_vld_reg, s_ok_reg, s_unproj_reg, s_rej_reg;
    logic signed [DATA_W-1:0] s_xn_reg, s_yn_reg, s_a_reg;

    logic                     m1_vld_reg, m1_ok_reg, m1_unproj_reg, m1_rej_reg;
    logic signed [63:0]       p1_reg, p2_reg, p3_reg;
    logic signed [32:0]       d_reg;
    logic signed [DATA_W-1:0] m1_yn_reg;

    logic                     c_vld_reg, c_ok_reg, c_unproj_reg, c_rej_reg;
    logic signed [64:0]       sum_reg;
    logic signed [NUMW-1:0]   num_reg;
    logic signed [63:0]       c_p3_reg;
    logic signed [DATA_W-1:0] c_yn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_vld_reg  <= 1'b0;
            m1_vld_reg <= 1'b0;
            c_vld_reg  <= 1'b0;
        end else if (en) begin
            s_vld_reg  <= vb_out;
            m1_vld_reg <= s_vld_reg;
            c_vld_reg  <= m1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_xn_reg     <= sat_xn.val;
            s_yn_reg     <= sat_yn.val;
            s_ok_reg     <= ctx1_out.unproj ? sat_yn.fit : (sat_xn.fit && sat_yn.fit);
            s_unproj_reg <= ctx1_out.unproj;
            s_rej_reg    <= ctx1_out.rej;
            s_a_reg      <= ctx1_out.a;

            p1_reg        <= 64'(cfg.focal_x) * 64'(s_xn_reg);
            p2_reg        <= 64'(cfg.skew) * 64'(s_yn_reg);
            p3_reg        <= 64'(cfg.focal_y) * 64'(s_yn_reg);
            d_reg         <= {s_a_reg[31], s_a_reg} - {cfg.center_x[31], cfg.center_x};
            m1_yn_reg     <= s_yn_reg;
            m1_ok_reg     <= s_ok_reg;
            m1_unproj_reg <= s_unproj_reg;
            m1_rej_reg    <= s_rej_reg;

            sum_reg      <= 65'(p1_reg) + 65'(p2_reg);
            num_reg      <= (NUMW'(d_reg) <<< FRAC_BITS) - NUMW'(p2_reg);
            c_p3_reg     <= p3_reg;
            c_yn_reg     <= m1_yn_reg;
            c_ok_reg     <= m1_ok_reg;
            c_unproj_reg <= m1_unproj_reg;
            c_rej_reg    <= m1_rej_reg;
        end
    end

    // Projection finishes here; unprojection goes on to the x division.
    logic signed [65:0] colw, roww;
    sat_t               sat_col, sat_row;
    logic [NUMW-1:0]    nmag;
    ctx2_t              ctx2_in, ctx2_out;
    logic               v2_out;
    logic [NUMW-1:0]    q2;
    logic [$bits(ctx2_t)-1:0] tag2_out;

    always_comb begin
        colw    = 66'(sum_reg >>> FRAC_BITS) + 66'(cfg.center_x);
        roww    = 66'(c_p3_reg >>> FRAC_BITS) + 66'(cfg.center_y);
        sat_col = wsat(colw);
        sat_row = wsat(roww);
        nmag    = num_reg[NUMW-1] ? (NUMW'(0) - num_reg) : num_reg;
        ctx2_in.unproj = c_unproj_reg;
        ctx2_in.rej    = c_rej_reg;
        ctx2_in.neg    = num_reg[NUMW-1];
        if (c_unproj_reg) begin
            ctx2_in.ok = c_ok_reg;
            ctx2_in.rx = '0;
            ctx2_in.ry = c_yn_reg;
        end else begin
            ctx2_in.ok = c_ok_reg && sat_col.fit && sat_row.fit;
            ctx2_in.rx = sat_col.val;
            ctx2_in.ry = sat_row.val;
        end
    end

    ppu_div #(.DW(NUMW), .VW(DATA_W), .TW($bits(ctx2_t))) u_div_c (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(c_vld_reg), .in_dividend(nmag), .in_divisor(cfg.focal_x),
        .in_tag(ctx2_in),
        .out_valid(v2_out), .out_quot(q2), .out_tag(tag2_out)
    );

    assign ctx2_out = ctx2_t'(tag2_out);

    sat_t sat_x2;
    assign sat_x2 = qsat(QMAXW'(q2), ctx2_out.neg);

    logic                     m_valid_reg, m_ok_reg;
    logic signed [DATA_W-1:0] m_x_reg, m_y_reg, m_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v2_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ctx2_out.rej) begin
                m_ok_reg <= 1'b0;
                m_x_reg  <= '0;
                m_y_reg  <= '0;
                m_z_reg  <= '0;
            end else if (ctx2_out.unproj) begin
                m_ok_reg <= ctx2_out.ok && sat_x2.fit;
                m_x_reg  <= sat_x2.val;
                m_y_reg  <= ctx2_out.ry;
                m_z_reg  <= ONE;
            end else begin
                m_ok_reg <= ctx2_out.ok;
                m_x_reg  <= ctx2_out.rx;
                m_y_reg  <= ctx2_out.ry;
                m_z_reg  <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_ok    = m_ok_reg;
    assign m_out_x = m_x_reg;
    assign m_out_y = m_y_reg;
    assign m_out_z = m_z_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ppu_pkg::*;

    typedef struct {
        opcode_t     op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } ray_req_t;

    typedef struct {
        logic        ok;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cam_res_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 250;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_wr_data;
    logic s_valid;
    logic s_ready;
    logic s_opcode;
    logic signed [DATA_W-1:0] s_in_x, s_in_y, s_in_z;
    logic m_valid;
    logic m_ready;
    logic m_ok;
    logic signed [DATA_W-1:0] m_out_x, m_out_y, m_out_z;

    pinhole_project_unproject_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_in_x(s_in_x), .s_in_y(s_in_y), .s_in_z(s_in_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z)
    );

    // Intrinsics as the block should currently hold them.
    logic        cam_ready;
    longint      cam_fx, cam_fy, cam_skew, cam_cx, cam_cy;

    ray_req_t pending_reqs[$];
    cam_res_t expected_pixels[$];
    ray_req_t cur_req;
    int  in_gap, out_hold;
    bit  quiet;
    int  mismatches, accepted, received, rejected_seen, cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp32(input logic signed [95:0] v, inout bit ok);
        if (v > 96'sh7FFF_FFFF) begin
            ok = 1'b0;
            return 64'sh7FFF_FFFF;
        end
        if (v < -96'sh8000_0000) begin
            ok = 1'b0;
            return -64'sh8000_0000;
        end
        return longint'(v);
    endfunction

    function automatic cam_res_t predict_pixel(input ray_req_t r);
        cam_res_t res;
        bit ok;
        logic signed [95:0] a, b, c, fx, fy, sk, cx, cy, xn, yn, num, acc;
        longint one;
        one = 64'sd65536;
        ok = 1'b1;
        a = r.x; b = r.y; c = r.z;
        fx = cam_fx; fy = cam_fy; sk = cam_skew; cx = cam_cx; cy = cam_cy;
        res = '{ok: 1'b0, x: '0, y: '0, z: '0};
        if (!cam_ready) begin
            ok = 1'b0;
        end else if (r.op == OP_PROJECT) begin
            if (c <= 0) begin
                ok = 1'b0;
            end else begin
                xn = clamp32((a * one) / c, ok);
                yn = clamp32((b * one) / c, ok);
                acc = (fx * xn + sk * yn) >>> 16;
                res.x = 32'(clamp32(acc + cx, ok));
                acc = (fy * yn) >>> 16;
                res.y = 32'(clamp32(acc + cy, ok));
                res.z = '0;
            end
        end else begin
            if (fx <= 0 || fy <= 0) begin
                ok = 1'b0;
            end else begin
                yn = clamp32(((b - cy) * one) / fy, ok);
                num = (a - cx) * one - sk * yn;
                res.x = 32'(clamp32(num / fx, ok));
                res.y = yn[31:0];
                res.z = 32'sd65536;
            end
        end
        res.ok = ok;
        return res;
    endfunction

    // Mix of full-range values, edge values and modest scene coordinates.
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(0, 3) - 1;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_depth();
        case ($urandom_range(0, 9))
            0: return -$signed($urandom_range(0, 1000));
            1: return $urandom;
            2: return $urandom_range(1, 16);
            default: return $urandom_range(32'h0000_4000, 32'h0080_0000);
        endcase
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_MODEL_READY: cam_ready = val[0];
            CFG_FOCAL_X:     cam_fx = longint'($signed(val));
            CFG_FOCAL_Y:     cam_fy = longint'($signed(val));
            CFG_SKEW:        cam_skew = longint'($signed(val));
            CFG_CENTER_X:    cam_cx = longint'($signed(val));
            CFG_CENTER_Y:    cam_cy = longint'($signed(val));
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_camera(input logic rdy, input logic [31:0] fx, input logic [31:0] fy,
                               input logic [31:0] sk, input logic [31:0] cx,
                               input logic [31:0] cy);
        write_reg(CFG_MODEL_READY, {31'd0, rdy});
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_SKEW, sk);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
    endtask

    task automatic queue_req(input opcode_t op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        ray_req_t r;
        r.op = op; r.x = x; r.y = y; r.z = z;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            queue_req(opcode_t'($urandom_range(0, 1)), pick_coord(), pick_coord(), pick_depth());
        end
    endtask

    // All expectations are met only after every pending transaction went through.
    task automatic settle();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_pixels.size() != 0);
    endtask

    // Driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pixels.push_back(predict_pixel(cur_req));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid  <= 1'b1;
                    s_opcode <= cur_req.op;
                    s_in_x   <= cur_req.x;
                    s_in_y   <= cur_req.y;
                    s_in_z   <= cur_req.z;
                    if (!quiet && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) out_hold = $urandom_range(1, 7);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        cam_res_t exp_px;
        if (aresetn && m_valid && m_ready) begin
            received++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction ok=%0b x=%0d",
                                               m_ok, m_out_x);
            end else begin
                exp_px = expected_pixels.pop_front();
                if (!exp_px.ok) rejected_seen++;
                if (m_ok !== exp_px.ok || m_out_x !== exp_px.x || m_out_y !== exp_px.y ||
                    m_out_z !== exp_px.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch #%0d: expected ok=%0b x=%0d y=%0d z=%0d, ",
                                  "got ok=%0b x=%0d y=%0d z=%0d"},
                                 received, exp_px.ok, exp_px.x, exp_px.y, exp_px.z,
                                 m_ok, m_out_x, m_out_y, m_out_z);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wr_data = '0;
        s_valid = 1'b0; s_opcode = 1'b0; s_in_x = '0; s_in_y = '0; s_in_z = '0;
        m_ready = 1'b0;
        quiet = 1'b0;
        mismatches = 0; accepted = 0; received = 0; rejected_seen = 0; cycles = 0;
        cam_ready = 1'b0; cam_fx = 65536; cam_fy = 65536;
        cam_skew = 0; cam_cx = 0; cam_cy = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset the model is not ready, so everything is rejected.
        queue_req(OP_PROJECT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000);
        queue_req(OP_UNPROJECT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0);
        queue_random(6);
        settle();

        load_camera(1'b1, 32'sh0200_0000, 32'sh01F0_0000, 32'sh0000_8000,
                    32'sh0140_0000, 32'sh00F0_0000);
        queue_req(OP_PROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        queue_req(OP_PROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'shFFFF_FFFF);
        queue_req(OP_PROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh8000_0000);
        queue_req(OP_PROJECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1);
        queue_req(OP_PROJECT, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        queue_req(OP_PROJECT, 32'shFFFF_0000, 32'sh0000_8000, 32'sh0004_0000);
        queue_req(OP_PROJECT, 32'sh0, 32'sh0, 32'sh0001_0000);
        queue_req(OP_UNPROJECT, 32'sh0140_0000, 32'sh00F0_0000, 32'sh0);
        queue_req(OP_UNPROJECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_req(OP_UNPROJECT, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_req(OP_UNPROJECT, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh5555_5555);
        queue_random(300);
        settle();

        // Tiny focal lengths and extreme skew drive the saturation paths.
        load_camera(1'b1, 32'sh0000_0001, 32'sh0000_0001, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_req(OP_PROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        queue_req(OP_UNPROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        queue_random(150);
        settle();

        load_camera(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_random(150);
        settle();

        // Non-positive focal lengths reject every unprojection.
        load_camera(1'b1, 32'sh0, 32'sh8000_0000, 32'shFFFF_0000, 32'sh0, 32'sh0);
        queue_req(OP_UNPROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0);
        queue_random(60);
        settle();
        write_reg(CFG_FOCAL_X, 32'sh0001_0000);
        queue_random(40);
        settle();

        for (int k = 0; k < 3; k++) begin
            load_camera(1'b1, $urandom_range(1, 32'h0400_0000), $urandom_range(1, 32'h0400_0000),
                        $urandom, $urandom, $urandom);
            queue_random(100);
            settle();
        end

        // The last stretch runs with no idling on either side.
        load_camera(1'b1, 32'sh0180_0000, 32'sh0180_0000, 32'sh0, 32'sh0100_0000,
                    32'sh00C0_0000);
        quiet = 1'b1;
        queue_random(100);
        settle();
        write_reg(CFG_MODEL_READY, 32'd0);
        queue_random(10);
        settle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_pixels.size() != 0) mismatches++;
        $display("sent %0d and checked %0d transactions (%0d with ok low)",
                 accepted, received, rejected_seen);
        $display("across eleven intrinsic settings; mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
